// ===== design/ddpp_pkg.sv =====
// Shared types and constants for the differential-drive path PI controller.
package ddpp_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_SPEED_PROP_GAIN      = 3'd0;
	localparam logic [2:0] REG_SPEED_INTEGRAL_GAIN  = 3'd1;
	localparam logic [2:0] REG_HEADING_PROP_GAIN    = 3'd2;
	localparam logic [2:0] REG_HEADING_INTEGRAL_GAIN = 3'd3;
	localparam logic [2:0] REG_SPEED_INTEGRAL_LIMIT = 3'd4;
	localparam logic [2:0] REG_HEADING_INTEGRAL_LIMIT = 3'd5;

	localparam int GAIN_W     = 24;
	localparam int SLIMIT_W   = 21;
	localparam int HLIMIT_W   = 15;
	localparam int ANGLE_W    = 15;
	localparam int SPEED_W    = 16;
	localparam int ERR_W      = 18;
	localparam int SSUM_W     = 22;
	localparam int HSUM_W     = 16;

	// Reset values of the configuration registers
	localparam logic [GAIN_W-1:0]   SPEED_PROP_GAIN_RST      = 24'd9830;
	localparam logic [GAIN_W-1:0]   SPEED_INTEGRAL_GAIN_RST  = 24'd655;
	localparam logic [GAIN_W-1:0]   HEADING_PROP_GAIN_RST    = 24'd1966080;
	localparam logic [GAIN_W-1:0]   HEADING_INTEGRAL_GAIN_RST = 24'd6554;
	localparam logic [SLIMIT_W-1:0] SPEED_INTEGRAL_LIMIT_RST = 21'd1024000;
	localparam logic [HLIMIT_W-1:0] HEADING_INTEGRAL_LIMIT_RST = 15'd12288;

	// Pi with twenty fraction bits, rounded to nearest in the angle format on use
	localparam int PI_Q20 = 3294199;

	localparam logic [SPEED_W-1:0] SAT_MAX = 16'h7FFF;
	localparam logic [SPEED_W-1:0] SAT_MIN = 16'h8000;

	// Errors of one control tick
	typedef struct packed {
		logic [ERR_W-1:0] err_h;
		logic [ERR_W-1:0] err_v;
		logic             rev;
	} err_t;

endpackage

// ===== design/differential_drive_path_pi.sv =====
// Differential-drive path follower: PI loops on speed and heading.
// An accepted input passes the input register and stage two to the result register.
// Throughput: one transaction per cycle; the integrator update sits in a single stage.
// The whole pipeline holds while a result waits on the master side.
// Reset clears the integrators and the valid flags and loads the register defaults.
module differential_drive_path_pi #(
	parameter int SPEED_FRAC_BITS = 8,
	parameter int ANGLE_FRAC_BITS = 12,
	parameter int GAIN_FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// path_heading[14:0], robot_heading[29:15], path_speed[45:30],
	// left_wheel_speed[61:46], right_wheel_speed[77:62], zero pad[79:78]
	input  logic [79:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// left_target[15:0], right_target[31:16]
	output logic [31:0] m_tdata,
	// drive_reversed[0]
	output logic        m_tuser,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_wdata
);
	localparam int OmegaShift = GAIN_FRAC_BITS + ANGLE_FRAC_BITS - SPEED_FRAC_BITS;
	localparam int ACC_W = 48;
	localparam int SUM_W = 49;
	localparam logic signed [ACC_W-1:0] V_HALF = ACC_W'(1) << (GAIN_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] W_HALF = ACC_W'(1) << (OmegaShift - 1);

	logic [ddpp_pkg::GAIN_W-1:0]   speed_prop_gain_q;
	logic [ddpp_pkg::GAIN_W-1:0]   speed_integral_gain_q;
	logic [ddpp_pkg::GAIN_W-1:0]   heading_prop_gain_q;
	logic [ddpp_pkg::GAIN_W-1:0]   heading_integral_gain_q;
	logic [ddpp_pkg::SLIMIT_W-1:0] speed_integral_limit_q;
	logic [ddpp_pkg::HLIMIT_W-1:0] heading_integral_limit_q;

	logic signed [ddpp_pkg::SSUM_W-1:0] speed_error_sum_q;
	logic signed [ddpp_pkg::HSUM_W-1:0] heading_error_sum_q;

	logic                                advance;
	logic                                valid_s1;
	logic signed [ddpp_pkg::ANGLE_W-1:0] path_heading_s1;
	logic signed [ddpp_pkg::ANGLE_W-1:0] robot_heading_s1;
	logic signed [ddpp_pkg::SPEED_W-1:0] path_speed_s1;
	logic signed [ddpp_pkg::SPEED_W-1:0] left_wheel_speed_s1;
	logic signed [ddpp_pkg::SPEED_W-1:0] right_wheel_speed_s1;

	ddpp_pkg::err_t err;
	ddpp_pkg::err_t err_s2;
	logic           valid_s2;

	logic signed [ddpp_pkg::SSUM_W:0]   speed_sum_next;
	logic signed [ddpp_pkg::SSUM_W:0]   speed_lim;
	logic signed [ddpp_pkg::SSUM_W-1:0] speed_sum_clamped;
	logic signed [ddpp_pkg::ERR_W:0]    heading_sum_next;
	logic signed [ddpp_pkg::ERR_W:0]    heading_lim;
	logic signed [ddpp_pkg::HSUM_W-1:0] heading_sum_clamped;

	logic signed [ddpp_pkg::GAIN_W:0]   g_sp;
	logic signed [ddpp_pkg::GAIN_W:0]   g_si;
	logic signed [ddpp_pkg::GAIN_W:0]   g_hp;
	logic signed [ddpp_pkg::GAIN_W:0]   g_hi;
	logic signed [ddpp_pkg::ERR_W-1:0]  ev_s2;
	logic signed [ddpp_pkg::ERR_W-1:0]  eh_s2;
	logic signed [42:0]                 p_sp;
	logic signed [46:0]                 p_si;
	logic signed [42:0]                 p_hp;
	logic signed [40:0]                 p_hi;
	logic signed [ACC_W-1:0]            v_acc;
	logic signed [ACC_W-1:0]            w_acc;
	logic signed [ACC_W-1:0]            v_cmd;
	logic signed [ACC_W-1:0]            w_cmd;
	logic signed [SUM_W-1:0]            left_raw;
	logic signed [SUM_W-1:0]            right_raw;
	logic [ddpp_pkg::SPEED_W-1:0]       left_sat;
	logic [ddpp_pkg::SPEED_W-1:0]       right_sat;

	logic [ddpp_pkg::SPEED_W-1:0] left_target_q;
	logic [ddpp_pkg::SPEED_W-1:0] right_target_q;
	logic                         drive_reversed_q;
	logic                         out_valid_q;

	// The pipeline moves whenever the output register is free or being emptied.
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {right_target_q, left_target_q};
	assign m_tuser  = drive_reversed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_prop_gain_q        <= ddpp_pkg::SPEED_PROP_GAIN_RST;
			speed_integral_gain_q    <= ddpp_pkg::SPEED_INTEGRAL_GAIN_RST;
			heading_prop_gain_q      <= ddpp_pkg::HEADING_PROP_GAIN_RST;
			heading_integral_gain_q  <= ddpp_pkg::HEADING_INTEGRAL_GAIN_RST;
			speed_integral_limit_q   <= ddpp_pkg::SPEED_INTEGRAL_LIMIT_RST;
			heading_integral_limit_q <= ddpp_pkg::HEADING_INTEGRAL_LIMIT_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				ddpp_pkg::REG_SPEED_PROP_GAIN: begin
					speed_prop_gain_q <= cfg_wdata;
				end
				ddpp_pkg::REG_SPEED_INTEGRAL_GAIN: begin
					speed_integral_gain_q <= cfg_wdata;
				end
				ddpp_pkg::REG_HEADING_PROP_GAIN: begin
					heading_prop_gain_q <= cfg_wdata;
				end
				ddpp_pkg::REG_HEADING_INTEGRAL_GAIN: begin
					heading_integral_gain_q <= cfg_wdata;
				end
				ddpp_pkg::REG_SPEED_INTEGRAL_LIMIT: begin
					speed_integral_limit_q <= cfg_wdata[ddpp_pkg::SLIMIT_W-1:0];
				end
				ddpp_pkg::REG_HEADING_INTEGRAL_LIMIT: begin
					heading_integral_limit_q <= cfg_wdata[ddpp_pkg::HLIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			path_heading_s1      <= s_tdata[14:0];
			robot_heading_s1     <= s_tdata[29:15];
			path_speed_s1        <= s_tdata[45:30];
			left_wheel_speed_s1  <= s_tdata[61:46];
			right_wheel_speed_s1 <= s_tdata[77:62];
		end
	end

	ddpp_err #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_err (
		.path_heading     (path_heading_s1),
		.robot_heading    (robot_heading_s1),
		.path_speed       (path_speed_s1),
		.left_wheel_speed (left_wheel_speed_s1),
		.right_wheel_speed(right_wheel_speed_s1),
		.err              (err)
	);

	// Integrator update with symmetric clamp
	always_comb begin
		speed_sum_next = (ddpp_pkg::SSUM_W+1)'(speed_error_sum_q) +
			(ddpp_pkg::SSUM_W+1)'(signed'(err.err_v));
		speed_lim = signed'((ddpp_pkg::SSUM_W+1)'(speed_integral_limit_q));
		if (speed_sum_next > speed_lim) begin
			speed_sum_clamped = speed_lim[ddpp_pkg::SSUM_W-1:0];
		end else if (speed_sum_next < -speed_lim) begin
			speed_sum_clamped = ddpp_pkg::SSUM_W'(-speed_lim);
		end else begin
			speed_sum_clamped = speed_sum_next[ddpp_pkg::SSUM_W-1:0];
		end

		heading_sum_next = (ddpp_pkg::ERR_W+1)'(heading_error_sum_q) +
			(ddpp_pkg::ERR_W+1)'(signed'(err.err_h));
		heading_lim = signed'((ddpp_pkg::ERR_W+1)'(heading_integral_limit_q));
		if (heading_sum_next > heading_lim) begin
			heading_sum_clamped = heading_lim[ddpp_pkg::HSUM_W-1:0];
		end else if (heading_sum_next < -heading_lim) begin
			heading_sum_clamped = ddpp_pkg::HSUM_W'(-heading_lim);
		end else begin
			heading_sum_clamped = heading_sum_next[ddpp_pkg::HSUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2            <= 1'b0;
			speed_error_sum_q   <= '0;
			heading_error_sum_q <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				speed_error_sum_q   <= speed_sum_clamped;
				heading_error_sum_q <= heading_sum_clamped;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			err_s2 <= err;
		end
	end

	// The integrators now hold the sums belonging to the item in stage two.
	always_comb begin
		g_sp  = signed'({1'b0, speed_prop_gain_q});
		g_si  = signed'({1'b0, speed_integral_gain_q});
		g_hp  = signed'({1'b0, heading_prop_gain_q});
		g_hi  = signed'({1'b0, heading_integral_gain_q});
		ev_s2 = signed'(err_s2.err_v);
		eh_s2 = signed'(err_s2.err_h);

		p_sp = g_sp * ev_s2;
		p_si = g_si * speed_error_sum_q;
		p_hp = g_hp * eh_s2;
		p_hi = g_hi * heading_error_sum_q;

		v_acc = ACC_W'(p_sp) + ACC_W'(p_si) + V_HALF;
		w_acc = ACC_W'(p_hp) + ACC_W'(p_hi) + W_HALF;
		v_cmd = v_acc >>> GAIN_FRAC_BITS;
		w_cmd = w_acc >>> OmegaShift;

		left_raw  = SUM_W'(v_cmd) + SUM_W'(w_cmd);
		right_raw = SUM_W'(v_cmd) - SUM_W'(w_cmd);

		if (left_raw > SUM_W'(signed'(ddpp_pkg::SAT_MAX))) begin
			left_sat = ddpp_pkg::SAT_MAX;
		end else if (left_raw < SUM_W'(signed'(ddpp_pkg::SAT_MIN))) begin
			left_sat = ddpp_pkg::SAT_MIN;
		end else begin
			left_sat = left_raw[ddpp_pkg::SPEED_W-1:0];
		end

		if (right_raw > SUM_W'(signed'(ddpp_pkg::SAT_MAX))) begin
			right_sat = ddpp_pkg::SAT_MAX;
		end else if (right_raw < SUM_W'(signed'(ddpp_pkg::SAT_MIN))) begin
			right_sat = ddpp_pkg::SAT_MIN;
		end else begin
			right_sat = right_raw[ddpp_pkg::SPEED_W-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			left_target_q    <= left_sat;
			right_target_q   <= right_sat;
			drive_reversed_q <= err_s2.rev;
		end
	end

endmodule

// ===== design/ddpp_err.sv =====
// Heading error wrap and fold, direction choice and speed error.
module ddpp_err #(
	parameter int ANGLE_FRAC_BITS = 12
) (
	input  logic signed [ddpp_pkg::ANGLE_W-1:0] path_heading,
	input  logic signed [ddpp_pkg::ANGLE_W-1:0] robot_heading,
	input  logic signed [ddpp_pkg::SPEED_W-1:0] path_speed,
	input  logic signed [ddpp_pkg::SPEED_W-1:0] left_wheel_speed,
	input  logic signed [ddpp_pkg::SPEED_W-1:0] right_wheel_speed,
	output ddpp_pkg::err_t                      err
);
	localparam int PiInt = (ddpp_pkg::PI_Q20 + (1 << (19 - ANGLE_FRAC_BITS)))
		>> (20 - ANGLE_FRAC_BITS);
	localparam int HalfPiInt = (ddpp_pkg::PI_Q20 + (1 << (20 - ANGLE_FRAC_BITS)))
		>> (21 - ANGLE_FRAC_BITS);
	localparam logic signed [ddpp_pkg::ERR_W-1:0] PI_Q      = ddpp_pkg::ERR_W'(PiInt);
	localparam logic signed [ddpp_pkg::ERR_W-1:0] TWO_PI_Q  = ddpp_pkg::ERR_W'(2 * PiInt);
	localparam logic signed [ddpp_pkg::ERR_W-1:0] HALF_PI_Q = ddpp_pkg::ERR_W'(HalfPiInt);

	logic signed [ddpp_pkg::ERR_W-1:0]   diff;
	logic signed [ddpp_pkg::ERR_W-1:0]   wrapped;
	logic signed [ddpp_pkg::ERR_W-1:0]   folded;
	logic                                rev;
	logic signed [ddpp_pkg::SPEED_W:0]   vp;
	logic signed [ddpp_pkg::SPEED_W:0]   wsum;
	logic signed [ddpp_pkg::SPEED_W:0]   wsum_adj;
	logic signed [ddpp_pkg::SPEED_W-1:0] mean;

	always_comb begin
		diff = ddpp_pkg::ERR_W'(path_heading) - ddpp_pkg::ERR_W'(robot_heading);

		// Single wrap into plus or minus pi
		if (diff > PI_Q) begin
			wrapped = diff - TWO_PI_Q;
		end else if (diff < -PI_Q) begin
			wrapped = diff + TWO_PI_Q;
		end else begin
			wrapped = diff;
		end

		// Beyond a quarter turn it is cheaper to drive backwards
		if (wrapped > HALF_PI_Q) begin
			rev    = 1'b1;
			folded = wrapped - PI_Q;
		end else if (wrapped < -HALF_PI_Q) begin
			rev    = 1'b1;
			folded = wrapped + PI_Q;
		end else begin
			rev    = 1'b0;
			folded = wrapped;
		end

		vp = rev ? -(ddpp_pkg::SPEED_W+1)'(path_speed) : (ddpp_pkg::SPEED_W+1)'(path_speed);

		// Wheel mean truncated toward zero: bias negative sums by one before the shift.
		wsum     = (ddpp_pkg::SPEED_W+1)'(left_wheel_speed) +
			(ddpp_pkg::SPEED_W+1)'(right_wheel_speed);
		wsum_adj = wsum + (ddpp_pkg::SPEED_W+1)'(wsum[ddpp_pkg::SPEED_W]);
		mean     = wsum_adj[ddpp_pkg::SPEED_W:1];

		err.err_h = folded;
		err.err_v = ddpp_pkg::ERR_W'(vp) - ddpp_pkg::ERR_W'(mean);
		err.rev   = rev;
	end

endmodule

// ===== tb/sv/differential_drive_path_pi_tb.sv =====
// Self-checking testbench for the differential-drive path PI controller.
`timescale 1ns / 100ps

module differential_drive_path_pi_tb;

	localparam int SPEED_FRAC = 8;
	localparam int ANGLE_FRAC = 12;
	localparam int GAIN_FRAC = 16;
	localparam int OMEGA_SHIFT = GAIN_FRAC + ANGLE_FRAC - SPEED_FRAC;
	localparam longint ANGLE_PI =
		(ddpp_pkg::PI_Q20 + (1 << (19 - ANGLE_FRAC))) >> (20 - ANGLE_FRAC);
	localparam longint ANGLE_HALF_PI =
		(ddpp_pkg::PI_Q20 + (1 << (20 - ANGLE_FRAC))) >> (21 - ANGLE_FRAC);
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int REPORT_LIMIT = 10;

	typedef enum {SET_DEFAULT, SET_MAX, SET_ZERO, SET_RANDOM} setting_t;

	typedef struct {
		logic [14:0] path_heading;
		logic [14:0] robot_heading;
		logic [15:0] path_speed;
		logic [15:0] left_speed;
		logic [15:0] right_speed;
		bit          wait_for_drain;
	} tick_t;

	typedef struct {
		logic [15:0] left_target;
		logic [15:0] right_target;
		logic        reversed;
	} wheel_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_wen = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_wdata = '0;

	tick_t      pending_ticks[$];
	wheel_cmd_t wheel_cmds_due[$];
	tick_t      next_tick;
	wheel_cmd_t cmd_expected;
	wheel_cmd_t cmd_observed;

	// Controller mirror: registers and integrators
	longint speed_kp, speed_ki, heading_kp, heading_ki, speed_limit, heading_limit;
	longint speed_err_sum, heading_err_sum;

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  stall_requests = 0;
	int  stall_seen = 0;
	int  stall_left = 0;
	int  error_count = 0;
	int  quiet_cycles = 0;
	bit  in_fire = 1'b0;

	differential_drive_path_pi #(
		.SPEED_FRAC_BITS(SPEED_FRAC),
		.ANGLE_FRAC_BITS(ANGLE_FRAC),
		.GAIN_FRAC_BITS(GAIN_FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp_sym(input longint x, input longint lim);
		if (x > lim) return lim;
		if (x < -lim) return -lim;
		return x;
	endfunction

	// Add half an output LSB, then shift arithmetically (floor).
	function automatic longint round_down_shift(input longint x, input int sh);
		return (x + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	function automatic logic [15:0] saturate16(input longint x);
		if (x > 32767) return ddpp_pkg::SAT_MAX;
		if (x < -32768) return ddpp_pkg::SAT_MIN;
		return x[15:0];
	endfunction

	function automatic void predict_wheel_cmd(input logic [79:0] d);
		longint ph, rh, vp, wl, wr, err_h, err_v, v, w;
		wheel_cmd_t cmd;
		ph = $signed(d[14:0]);
		rh = $signed(d[29:15]);
		vp = $signed(d[45:30]);
		wl = $signed(d[61:46]);
		wr = $signed(d[77:62]);
		cmd.reversed = 1'b0;
		// The heading error is wrapped once only, even for headings beyond pi.
		err_h = ph - rh;
		if (err_h > ANGLE_PI) err_h -= 2 * ANGLE_PI;
		else if (err_h < -ANGLE_PI) err_h += 2 * ANGLE_PI;
		if (err_h > ANGLE_HALF_PI) begin
			cmd.reversed = 1'b1;
			vp = -vp;
			err_h -= ANGLE_PI;
		end else if (err_h < -ANGLE_HALF_PI) begin
			cmd.reversed = 1'b1;
			vp = -vp;
			err_h += ANGLE_PI;
		end
		err_v = vp - (wl + wr) / 2;
		speed_err_sum = clamp_sym(speed_err_sum + err_v, speed_limit);
		heading_err_sum = clamp_sym(heading_err_sum + err_h, heading_limit);
		v = round_down_shift(speed_kp * err_v + speed_ki * speed_err_sum, GAIN_FRAC);
		w = round_down_shift(heading_kp * err_h + heading_ki * heading_err_sum, OMEGA_SHIFT);
		cmd.left_target = saturate16(v + w);
		cmd.right_target = saturate16(v - w);
		wheel_cmds_due.push_back(cmd);
	endfunction

	function automatic void report_error(input string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	// Input driver: a transaction is held until the block takes it.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_fire) begin
			if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct &&
			    !(pending_ticks[0].wait_for_drain && wheel_cmds_due.size() != 0)) begin
				next_tick = pending_ticks.pop_front();
				s_tdata <= {2'b00, next_tick.right_speed, next_tick.left_speed,
				            next_tick.path_speed, next_tick.robot_heading,
				            next_tick.path_heading};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver, with an occasional long hold-off to back the pipeline up.
	always @(negedge clk) begin
		if (stall_seen != stall_requests) begin
			stall_seen <= stall_requests;
			stall_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor, checker and watchdog.
	always @(posedge clk) begin
		in_fire <= arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			cmd_observed.left_target = m_tdata[15:0];
			cmd_observed.right_target = m_tdata[31:16];
			cmd_observed.reversed = m_tuser;
			if (wheel_cmds_due.size() == 0) begin
				report_error($sformatf("result with nothing expected: left %0d right %0d rev %0b",
				             $signed(cmd_observed.left_target),
				             $signed(cmd_observed.right_target), cmd_observed.reversed));
			end else begin
				cmd_expected = wheel_cmds_due.pop_front();
				if (cmd_observed.left_target !== cmd_expected.left_target)
					report_error($sformatf("left_target expected %0d, got %0d",
					             $signed(cmd_expected.left_target),
					             $signed(cmd_observed.left_target)));
				if (cmd_observed.right_target !== cmd_expected.right_target)
					report_error($sformatf("right_target expected %0d, got %0d",
					             $signed(cmd_expected.right_target),
					             $signed(cmd_observed.right_target)));
				if (cmd_observed.reversed !== cmd_expected.reversed)
					report_error($sformatf("drive_reversed expected %0b, got %0b",
					             cmd_expected.reversed, cmd_observed.reversed));
			end
		end
		if (arst_n && s_tvalid && s_tready) predict_wheel_cmd(s_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			ddpp_pkg::REG_SPEED_PROP_GAIN:       speed_kp = value;
			ddpp_pkg::REG_SPEED_INTEGRAL_GAIN:   speed_ki = value;
			ddpp_pkg::REG_HEADING_PROP_GAIN:     heading_kp = value;
			ddpp_pkg::REG_HEADING_INTEGRAL_GAIN: heading_ki = value;
			ddpp_pkg::REG_SPEED_INTEGRAL_LIMIT:
				speed_limit = value[ddpp_pkg::SLIMIT_W-1:0];
			ddpp_pkg::REG_HEADING_INTEGRAL_LIMIT:
				heading_limit = value[ddpp_pkg::HLIMIT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input setting_t kind);
		case (kind)
			SET_DEFAULT: begin
				write_reg(ddpp_pkg::REG_SPEED_PROP_GAIN, ddpp_pkg::SPEED_PROP_GAIN_RST);
				write_reg(ddpp_pkg::REG_SPEED_INTEGRAL_GAIN,
				          ddpp_pkg::SPEED_INTEGRAL_GAIN_RST);
				write_reg(ddpp_pkg::REG_HEADING_PROP_GAIN, ddpp_pkg::HEADING_PROP_GAIN_RST);
				write_reg(ddpp_pkg::REG_HEADING_INTEGRAL_GAIN,
				          ddpp_pkg::HEADING_INTEGRAL_GAIN_RST);
				write_reg(ddpp_pkg::REG_SPEED_INTEGRAL_LIMIT,
				          24'(ddpp_pkg::SPEED_INTEGRAL_LIMIT_RST));
				write_reg(ddpp_pkg::REG_HEADING_INTEGRAL_LIMIT,
				          24'(ddpp_pkg::HEADING_INTEGRAL_LIMIT_RST));
			end
			SET_MAX: begin
				write_reg(ddpp_pkg::REG_SPEED_PROP_GAIN, 24'hFFFFFF);
				write_reg(ddpp_pkg::REG_SPEED_INTEGRAL_GAIN, 24'hFFFFFF);
				write_reg(ddpp_pkg::REG_HEADING_PROP_GAIN, 24'hFFFFFF);
				write_reg(ddpp_pkg::REG_HEADING_INTEGRAL_GAIN, 24'hFFFFFF);
				write_reg(ddpp_pkg::REG_SPEED_INTEGRAL_LIMIT, 24'h1FFFFF);
				write_reg(ddpp_pkg::REG_HEADING_INTEGRAL_LIMIT, 24'h007FFF);
			end
			SET_ZERO: begin
				write_reg(ddpp_pkg::REG_SPEED_PROP_GAIN, '0);
				write_reg(ddpp_pkg::REG_SPEED_INTEGRAL_GAIN, '0);
				write_reg(ddpp_pkg::REG_HEADING_PROP_GAIN, '0);
				write_reg(ddpp_pkg::REG_HEADING_INTEGRAL_GAIN, '0);
				write_reg(ddpp_pkg::REG_SPEED_INTEGRAL_LIMIT, '0);
				write_reg(ddpp_pkg::REG_HEADING_INTEGRAL_LIMIT, '0);
			end
			default: begin
				// Moderate gains keep the outputs mostly out of saturation.
				write_reg(ddpp_pkg::REG_SPEED_PROP_GAIN, 24'($urandom_range(131072)));
				write_reg(ddpp_pkg::REG_SPEED_INTEGRAL_GAIN, 24'($urandom_range(8192)));
				write_reg(ddpp_pkg::REG_HEADING_PROP_GAIN, 24'($urandom_range(2097152)));
				write_reg(ddpp_pkg::REG_HEADING_INTEGRAL_GAIN, 24'($urandom_range(65536)));
				write_reg(ddpp_pkg::REG_SPEED_INTEGRAL_LIMIT, 24'($urandom_range(2097151)));
				write_reg(ddpp_pkg::REG_HEADING_INTEGRAL_LIMIT, 24'($urandom_range(32767)));
			end
		endcase
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic add_tick(input int ph, input int rh, input int vp, input int wl, input int wr,
	                        input bit drain);
		tick_t t;
		t.path_heading = 15'(ph);
		t.robot_heading = 15'(rh);
		t.path_speed = 16'(vp);
		t.left_speed = 16'(wl);
		t.right_speed = 16'(wr);
		t.wait_for_drain = drain;
		pending_ticks.push_back(t);
	endtask

	function automatic int rand_heading();
		if ($urandom_range(99) < 80) return int'($urandom_range(25736)) - 12868;
		return int'($urandom_range(32767)) - 16384;
	endfunction

	function automatic int rand_speed();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) return int'($urandom_range(2047)) - 1024;
		if (pick < 85) return int'($urandom_range(65535)) - 32768;
		case (pick % 4)
			0: return -32768;
			1: return 32767;
			2: return 0;
			default: return -1;
		endcase
	endfunction

	task automatic wait_until_drained();
		while (pending_ticks.size() != 0 || s_tvalid || wheel_cmds_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input setting_t kind, input int count, input int send_pct,
	                         input int recv_pct, input bit with_hold, input bit with_drain);
		apply_setting(kind);
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		if (with_hold) stall_requests++;
		for (int i = 0; i < count; i++)
			add_tick(rand_heading(), rand_heading(), rand_speed(), rand_speed(), rand_speed(),
			         with_drain && i == count / 2);
		wait_until_drained();
	endtask

	initial begin
		speed_kp = ddpp_pkg::SPEED_PROP_GAIN_RST;
		speed_ki = ddpp_pkg::SPEED_INTEGRAL_GAIN_RST;
		heading_kp = ddpp_pkg::HEADING_PROP_GAIN_RST;
		heading_ki = ddpp_pkg::HEADING_INTEGRAL_GAIN_RST;
		speed_limit = ddpp_pkg::SPEED_INTEGRAL_LIMIT_RST;
		heading_limit = ddpp_pkg::HEADING_INTEGRAL_LIMIT_RST;
		speed_err_sum = 0;
		heading_err_sum = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed ticks under the reset settings.
		send_idle_pct = 10;
		recv_idle_pct = 77;
		add_tick(0, 0, 0, 0, 0, 1'b0);
		add_tick(12868, -12868, 256, 256, 256, 1'b0);
		add_tick(-12868, 12868, 256, 0, 0, 1'b0);
		add_tick(6434, 0, 512, 0, 0, 1'b0);
		add_tick(6435, 0, 512, 0, 0, 1'b0);
		add_tick(-6434, 0, -512, 0, 0, 1'b0);
		add_tick(-6435, 0, -512, 0, 0, 1'b0);
		// Headings beyond pi: a single wrap, then the half-pi test.
		add_tick(16383, -16384, 100, 0, 0, 1'b0);
		add_tick(-16384, 16383, 100, 0, 0, 1'b0);
		add_tick(-16384, -16384, 32767, 32767, 32767, 1'b0);
		// Reversing the most negative speed gives plus 32768 in full width.
		add_tick(8000, 0, -32768, 0, 0, 1'b0);
		add_tick(-8000, 0, -32768, -32768, -32768, 1'b0);
		add_tick(0, 0, -1, 0, -1, 1'b0);
		add_tick(0, 0, 0, -3, 0, 1'b0);
		add_tick(0, 0, 0, 32767, -32768, 1'b0);
		// Drive the heading integrator into its clamp, then back out.
		for (int i = 0; i < 4; i++) add_tick(12868, 6000, 32767, -32768, -32768, 1'b0);
		for (int i = 0; i < 4; i++) add_tick(-12868, -6000, -32768, 32767, 32767, 1'b0);
		wait_until_drained();

		run_phase(SET_RANDOM, 250, 10, 77, 1'b1, 1'b0);
		run_phase(SET_MAX, 150, 77, 10, 1'b0, 1'b0);
		run_phase(SET_ZERO, 100, 77, 10, 1'b0, 1'b1);
		run_phase(SET_RANDOM, 250, 0, 0, 1'b1, 1'b1);
		run_phase(SET_DEFAULT, 250, 0, 0, 1'b0, 1'b0);

		if (error_count == 0 && wheel_cmds_due.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
